// File: hdl/ssd_pkg.sv
// Package for the seven-segment scan driver: field widths, codes, result
// and converter status types, segment and power-of-ten tables.
// No dependencies; every other file in hdl/ depends on it.
package ssd_pkg;

	localparam int DIGITS_DEF = 6;
	localparam int TPS_DEF    = 1000;

	localparam int VAL_W   = 20;
	localparam int OP_W    = 2;
	localparam int WORD_W  = 16;
	localparam int STAT_W  = 2;
	localparam int DOT_W   = 6;
	localparam int DUR_W   = 12;
	localparam int DUR_MAX = 4095;
	localparam int SCAN_W  = 3;   // holds any scan position up to eight digits
	localparam int TAB_W   = 27;  // holds 9 * 10^7
	localparam int PADDR_W = 3;
	localparam int REG_SEL_BIT = 2;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	localparam logic REG_DOT_MASK = 1'b0;
	localparam logic REG_DURATION = 1'b1;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
	localparam logic [OP_W-1:0] OP_ABORT = 2'd2;

	localparam logic [STAT_W-1:0] ST_SCAN  = 2'd0;
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_ABORT = 2'd2;

	localparam logic [WORD_W-1:0] BLANK_WORD = 16'h0000;
	localparam logic [VAL_W-1:0]  DIG_MOD    = 20'd1000000;

	typedef struct packed {
		logic [WORD_W-1:0] seg_word;
		logic [STAT_W-1:0] status;
		logic              last;
	} res_t;

	// converter status seen by the top level
	typedef struct packed {
		logic              discard;  // working on digits above the display width
		logic              wr;       // digit below is valid for position pos
		logic [SCAN_W-1:0] pos;
		logic [3:0]        digit;
	} conv_stat_t;

	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h27;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

	function automatic logic [TAB_W-1:0] pow10(input logic [2:0] k);
		logic [TAB_W-1:0] p;
		case (k)
			3'd0: p = TAB_W'(1);
			3'd1: p = TAB_W'(10);
			3'd2: p = TAB_W'(100);
			3'd3: p = TAB_W'(1000);
			3'd4: p = TAB_W'(10000);
			3'd5: p = TAB_W'(100000);
			3'd6: p = TAB_W'(1000000);
			default: p = TAB_W'(10000000);
		endcase
		return p;
	endfunction

endpackage

// File: hdl/ssd_ifs.sv
// Valid/ready channel interfaces of the scan driver: command items in,
// display word items out. Depends on ssd_pkg for field widths.
interface ssd_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [ssd_pkg::OP_W-1:0]  op;
	logic [ssd_pkg::VAL_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface ssd_disp_if;
	logic                       valid;
	logic                       ready;
	logic [ssd_pkg::WORD_W-1:0] seg_word;
	logic [ssd_pkg::STAT_W-1:0] status;
	logic                       last;

	modport source (output valid, output seg_word, output status, output last, input ready);
	modport sink (input valid, input seg_word, input status, input last, output ready);
endinterface

// File: hdl/ssd_digit_conv.sv
// Binary to decimal digit converter, one digit per cycle, most significant
// first, starting on a load. Depends on ssd_pkg (pow10, conv_stat_t).
module ssd_digit_conv #(
	parameter int DIGITS = ssd_pkg::DIGITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ssd_pkg::VAL_W-1:0] value,
	output ssd_pkg::conv_stat_t       stat
);
	import ssd_pkg::*;

	// top power of ten handled; for six digits or fewer the value is first
	// reduced below 10^6, which is a multiple of 10^DIGITS
	localparam int K0 = ((DIGITS > 6) ? DIGITS : 6) - 1;
	localparam int KW = $clog2(K0 + 1);

	logic             busy_q;
	logic [KW-1:0]    k_q;
	logic [VAL_W-1:0] rem_q;

	logic [TAB_W-1:0] pw;
	logic [TAB_W-1:0] thr;
	logic [TAB_W-1:0] sub;
	logic [3:0]       dig;
	logic [VAL_W-1:0] rem_next;
	logic [VAL_W-1:0] reduced;
	logic             discard;

	always_comb begin
		pw  = pow10(3'(k_q));
		dig = '0;
		sub = '0;
		thr = '0;
		for (int m = 1; m <= 9; m++) begin
			thr = TAB_W'(m) * pw;
			if (TAB_W'(rem_q) >= thr) begin
				dig = 4'(m);
				sub = thr;
			end
		end
		rem_next = rem_q - sub[VAL_W-1:0];
	end

	assign reduced = (DIGITS <= 6 && value >= DIG_MOD) ? value - DIG_MOD : value;
	assign discard = busy_q && (int'(k_q) >= DIGITS);

	always_comb begin
		stat.discard = discard;
		stat.wr      = busy_q && !discard;
		stat.pos     = SCAN_W'(DIGITS - 1 - int'(k_q));
		stat.digit   = dig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= KW'(K0);
		end else if (busy_q) begin
			if (k_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= reduced;
		end else if (busy_q) begin
			rem_q <= rem_next;
		end
	end

endmodule

// File: hdl/seven_segment_scan_driver_core.sv
// Multiplexed seven-segment scan driver, top level.
// Throughput: one item per cycle while ready is high; results leave through a
// four-entry queue. Ready is low while the queue holds three or more results
// or the digit converter, restarted by each load, works on digits above the
// display width, as it does first when DIGITS is under six. Ticks overlap it.
// Reset (arst_n, async, active low): idle session, empty queue, registers at defaults.
module seven_segment_scan_driver_core #(
	parameter int DIGITS        = ssd_pkg::DIGITS_DEF,
	parameter int TICKS_PER_SEC = ssd_pkg::TPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ssd_cmd_if.sink                     cmd,
	ssd_disp_if.source                  disp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import ssd_pkg::*;

	localparam int IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int LIMIT_W = $clog2(longint'(DUR_MAX) * TICKS_PER_SEC + 1);
	localparam logic [LIMIT_W-1:0] TPS_C = LIMIT_W'(TICKS_PER_SEC);
	localparam logic [IDX_W-1:0]   LAST_POS = IDX_W'(DIGITS - 1);

	// configuration
	logic [DOT_W-1:0]   dot_mask_q;
	logic [DUR_W-1:0]   duration_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               cfg_wr;
	logic               reg_sel;
	logic [DUR_W-1:0]   dur_in;
	logic [DUR_W-1:0]   dur_eff;

	// session state
	logic               active_q;
	logic [IDX_W-1:0]   scan_q;
	logic [LIMIT_W-1:0] tick_q;
	logic [3:0]         digit_q [DIGITS];

	conv_stat_t         conv_st;
	logic               acc;
	logic               load_go;
	logic               tick_go;
	logic               abort_go;
	logic               sess_end;
	logic [3:0]         cur_digit;
	logic [7:0]         dot_ext;
	logic [WORD_W-1:0]  tick_word;

	// result queue
	res_t               q_mem [Q_DEPTH];
	logic [Q_AW-1:0]    wr_ptr_q;
	logic [Q_AW-1:0]    rd_ptr_q;
	logic [Q_CW-1:0]    cnt_q;
	logic [1:0]         push_n;
	res_t               ent0;
	res_t               ent1;
	logic               pop;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[REG_SEL_BIT];
	assign dur_in  = pwdata[DUR_W-1:0];
	assign dur_eff = (dur_in == '0) ? DUR_W'(1) : dur_in;

	always_comb begin
		case (reg_sel)
			REG_DOT_MASK: prdata = 32'(dot_mask_q);
			REG_DURATION: prdata = 32'(duration_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_mask_q <= '0;
			duration_q <= DUR_W'(1);
			limit_q    <= TPS_C;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_DOT_MASK: dot_mask_q <= pwdata[DOT_W-1:0];
				REG_DURATION: begin
					duration_q <= dur_in;
					limit_q    <= LIMIT_W'(dur_eff) * TPS_C;
				end
				default: ;
			endcase
		end
	end

	// ---------------- digit converter ----------------
	ssd_digit_conv #(
		.DIGITS(DIGITS)
	) u_conv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (load_go),
		.value (cmd.value),
		.stat  (conv_st)
	);

	always_ff @(posedge clk) begin
		if (conv_st.wr) begin
			digit_q[conv_st.pos[IDX_W-1:0]] <= conv_st.digit;
		end
	end

	// ---------------- item decode ----------------
	assign cmd.ready = (cnt_q <= Q_CW'(Q_DEPTH - 2)) && !conv_st.discard;
	assign acc       = cmd.valid && cmd.ready;

	always_comb begin
		load_go  = 1'b0;
		tick_go  = 1'b0;
		abort_go = 1'b0;
		case (cmd.op)
			OP_LOAD:  load_go  = acc;
			OP_TICK:  tick_go  = acc && active_q;
			OP_ABORT: abort_go = acc && active_q;
			default: ;
		endcase
	end

	// the digit under scan may still be in the converter this cycle
	assign cur_digit = (conv_st.wr && conv_st.pos[IDX_W-1:0] == scan_q) ?
		conv_st.digit : digit_q[scan_q];
	assign dot_ext   = 8'(dot_mask_q);
	assign tick_word = {~(8'b1 << scan_q), dot_ext[3'(scan_q)], seg_of(cur_digit)};
	assign sess_end  = tick_q >= limit_q;

	always_comb begin
		push_n = 2'd0;
		ent0   = '{seg_word: tick_word, status: ST_SCAN, last: 1'b1};
		ent1   = '{seg_word: BLANK_WORD, status: ST_DONE, last: 1'b1};
		if (tick_go) begin
			if (sess_end) begin
				push_n    = 2'd2;
				ent0.last = 1'b0;
			end else begin
				push_n = 2'd1;
			end
		end else if (abort_go) begin
			push_n = 2'd1;
			ent0   = '{seg_word: BLANK_WORD, status: ST_ABORT, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			scan_q   <= '0;
			tick_q   <= '0;
		end else if (load_go) begin
			active_q <= 1'b1;
			scan_q   <= '0;
			tick_q   <= '0;
		end else if (tick_go) begin
			scan_q <= (scan_q == LAST_POS) ? '0 : scan_q + 1'b1;
			tick_q <= tick_q + 1'b1;
			if (sess_end) begin
				active_q <= 1'b0;
			end
		end else if (abort_go) begin
			active_q <= 1'b0;
		end
	end

	// ---------------- result queue ----------------
	assign pop           = disp.valid && disp.ready;
	assign disp.valid    = cnt_q != '0;
	assign disp.seg_word = q_mem[rd_ptr_q].seg_word;
	assign disp.status   = q_mem[rd_ptr_q].status;
	assign disp.last     = q_mem[rd_ptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + Q_AW'(pop);
			cnt_q    <= cnt_q + Q_CW'(push_n) - Q_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem[wr_ptr_q] <= ent0;
		end
		if (push_n == 2'd2) begin
			q_mem[wr_ptr_q + 1'b1] <= ent1;
		end
	end

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CW'(Q_DEPTH))
		else $error("result queue count exceeds depth");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(scan_q) < DIGITS)
		else $error("scan position out of range");

	a_scan_behind_conv: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && conv_st.wr |-> scan_q <= conv_st.pos[IDX_W-1:0])
		else $error("scan overtook the digit converter");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_go |=> active_q && scan_q == '0 && tick_q == '0)
		else $error("load did not restart the session");
`endif

endmodule
